[sv/vmd_pkg.sv]
// Shared types and constants for the MSB-first 7-bit varint decoder.
package vmd_pkg;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_status;

    // Decode modes
    localparam t_mode MODE_FULL  = 2'd0;
    localparam t_mode MODE_CLAMP = 2'd1;
    localparam t_mode MODE_CHECK = 2'd2;

    // Result status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_TRUNCATED = 2'd1;
    localparam t_status ST_TOO_LARGE = 2'd2;

    // Register indexes
    localparam logic REG_DECODE_MODE = 1'b0;

    localparam logic [31:0] OVF_LIMIT_HI = 32'h01FF_FFFF;
    localparam logic [6:0]  PAYLOAD_MASK = 7'h7F;
    localparam logic [31:0] MAX_32       = 32'hFFFF_FFFF;
    localparam logic [63:0] ALL_ONES_64  = 64'hFFFF_FFFF_FFFF_FFFF;

    // Configuration seen by the decode datapath
    typedef struct packed {
        t_mode decode_mode;
    } t_cfg;

endpackage

[sv/vmd_in_if.sv]
// Input channel: one encoded byte plus the buffer bound per transaction.
interface vmd_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [31:0] bytes_available;

    modport source (output valid, output data_byte, output bytes_available, input ready);
    modport sink   (input valid, input data_byte, input bytes_available, output ready);
endinterface

[sv/vmd_out_if.sv]
// Output channel: one decoded number per transaction.
interface vmd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [31:0] length;
    logic [1:0]  status;

    modport source (output valid, output value, output length, output status, input ready);
    modport sink   (input valid, input value, input length, input status, output ready);
endinterface

[sv/varint_msb_first_decoder.sv]
// Top level: MSB-first 7-bit varint decoder, one byte per unstalled cycle.
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    data_byte[7:0], bytes_available[31:0]
//  o_out     out  valid/ready    value[63:0], length[31:0], status[1:0]
//  apb       in   psel/penable   paddr[2:0], pwdata[31:0] -> prdata[31:0]
//
// Throughput is one byte per cycle while the result is not stalled; the path
// runs through the input register, then the decode step into the result
// register. The decode step (shift, add, bound compare, length subtract and
// compare) is combinational and updates the number state registers.
// Reset is synchronous and clears the number state, the mode and all valids.
// A stalled result holds the result register; input still flows until the
// input register also fills and needs the result register.
module varint_msb_first_decoder
    import vmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    vmd_in_if.sink      i_in,
    vmd_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg w_cfg;

    vmd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [31:0] r_in_avail;

    // Number state
    logic [63:0] r_acc,   n_acc;
    logic        r_ovf,   n_ovf;
    logic [31:0] r_count, n_count;

    // Result register
    logic        r_out_valid;
    logic [63:0] r_out_value,  n_out_value;
    logic [31:0] r_out_length, n_out_length;
    t_status     r_out_status, n_out_status;

    logic        w_step;
    logic        w_emit;
    logic        w_in_ready;
    logic        w_check;
    logic        w_bounded;
    logic        w_early_trunc;
    logic        w_late_trunc;
    logic        w_len_fail;
    logic [63:0] w_shifted;
    logic [63:0] w_value;
    logic [31:0] w_left;

    assign w_step     = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_ready = !r_in_valid || w_step;
    assign i_in.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in_byte  <= i_in.data_byte;
            r_in_avail <= i_in.bytes_available;
        end
    end

    // Decode step
    always_comb begin
        w_check       = w_cfg.decode_mode >= MODE_CHECK;
        w_bounded     = w_check || (r_in_avail != 32'd0);
        w_early_trunc = w_bounded && (r_count >= r_in_avail);

        w_shifted = {r_acc[56:0], r_in_byte[6:0] & PAYLOAD_MASK};
        n_ovf     = r_ovf || (r_acc[63:32] > OVF_LIMIT_HI);
        n_acc     = w_shifted;
        n_count   = (r_count == MAX_32) ? r_count : r_count + 32'd1;

        w_late_trunc = r_in_byte[7] && w_bounded && (n_count >= r_in_avail);

        w_value = n_ovf ? ALL_ONES_64 : w_shifted;
        if ((w_cfg.decode_mode >= MODE_CLAMP) && (w_value[63:32] != 32'd0)) begin
            w_value = {32'd0, MAX_32};
        end
        w_left     = r_in_avail - n_count;
        w_len_fail = w_check && (w_value > {32'd0, w_left});

        w_emit       = 1'b1;
        n_out_value  = 64'd0;
        n_out_length = 32'd0;
        n_out_status = ST_TRUNCATED;
        if (w_early_trunc || w_late_trunc) begin
            n_out_status = ST_TRUNCATED;
        end else if (r_in_byte[7]) begin
            w_emit = 1'b0;
        end else if (w_len_fail) begin
            n_out_status = ST_TOO_LARGE;
        end else begin
            n_out_value  = w_value;
            n_out_length = n_count;
            n_out_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 64'd0;
            r_ovf       <= 1'b0;
            r_count     <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                // Clear the number after every result, else advance it
                if (w_emit) begin
                    r_acc   <= 64'd0;
                    r_ovf   <= 1'b0;
                    r_count <= 32'd0;
                end else begin
                    r_acc   <= n_acc;
                    r_ovf   <= n_ovf;
                    r_count <= n_count;
                end
            end
            if (w_step && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out_value  <= n_out_value;
            r_out_length <= n_out_length;
            r_out_status <= n_out_status;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_out_value;
    assign o_out.length = r_out_length;
    assign o_out.status = r_out_status;

`ifndef ASSERT_OFF
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_emit) |=> (r_acc == 64'd0 && !r_ovf && r_count == 32'd0))
        else $error("number state not cleared after result");

    a_fail_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |->
            (r_out_value == 64'd0 && r_out_length == 32'd0))
        else $error("failed result carries nonzero value or length");

    a_ok_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_OK) |-> (r_out_length != 32'd0))
        else $error("ok result with zero length");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_ready |-> (r_out_valid && !o_out.ready))
        else $error("input stalled without a stalled result");
`endif

endmodule

[sv/vmd_cfg.sv]
// APB-style configuration register block for the varint decoder.
module vmd_cfg
    import vmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_mode r_decode_mode;
    logic  w_wr_en;

    assign pready  = 1'b1;
    assign w_wr_en = psel && penable && pwrite && (paddr[2] == REG_DECODE_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= MODE_FULL;
        end else if (w_wr_en) begin
            r_decode_mode <= pwdata[1:0];
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DECODE_MODE: prdata = {30'd0, r_decode_mode};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg.decode_mode = r_decode_mode;

endmodule
